// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ring request scheduler modules.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset
`define RRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included
`define RRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define RRS_ASSERT(lbl, prop, msg)
`define RRS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/rrs_pkg.sv =====
// Package of the ring request scheduler: sizes, codes and the command and
// status structs between controller and datapath. No dependencies.
`default_nettype none

package rrs_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRY_W     = 10;   // kind (2) and station (8)

  // Port field widths
  localparam int unsigned STN_W  = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned OUT_W  = 6;

  // Ring distances run from -255 to 255; the sentinel stands in for "far"
  localparam int unsigned DIST_W = 11;
  localparam logic signed [DIST_W-1:0] FAR_DIST = {1'b0, {(DIST_W-1){1'b1}}};

  // Operation codes
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_PICK    = 2'd1,
    OP_STOP    = 2'd2,
    OP_PASSING = 2'd3
  } op_e;

  // Strategy codes
  localparam logic [1:0] MODE_FIFO    = 2'd0;
  localparam logic [1:0] MODE_NEAREST = 2'd1;
  localparam logic [1:0] MODE_SWEEP   = 2'd2;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_TOTAL = 1'b1;

  // Reset values of the configuration registers
  localparam logic [1:0]       MODE_RESET  = MODE_FIFO;
  localparam logic [STN_W-1:0] TOTAL_RESET = 8'd10;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // take the input item
    logic insert;     // append the captured request
    logic scan_init;  // clear the scan counters
    logic scan_run;   // walk the table one entry a cycle
    logic finish;     // commit the new entry count
    logic load_out;   // move the result to the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_insert;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/ring_request_scheduler_top.sv =====
// Ring request scheduler, top level: controller and datapath.
// Depends on rrs_pkg, rrs_ctrl, rrs_dp (with rrs_ram).
//
// Use: one item on the input channel (in_valid_i / in_stall_o) carries an
// opcode and its arguments; the block answers with exactly one result item
// on the output channel (out_valid_o / out_stall_i). Configuration (mode and
// ring size) is written through cfg_valid_i / cfg_ready_o, cfg_index_i and
// cfg_data_i; the user must write it only while no item is in flight, as the
// block does not enforce this. cfg_ready_o is always high. An insert goes
// through the start and done states and its result is then loaded into the
// output register. Pick, serve stop and serve passing walk the request table
// through the single read port of the table RAM, one entry a cycle, before
// the done state. One item is worked on at a time; the next one is taken in
// the cycle after the result is loaded into the output register, even while
// the receiver is still stalling it. A stalled result holds; a finished item
// waits in the controller until the output register is free.
// Reset: the table is empty, mode is first-come first-served, the ring has
// ten stations. Table entries are not cleared; only the count is.
`default_nettype none

module ring_request_scheduler_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [rrs_pkg::STN_W-1:0]     cfg_data_i,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [rrs_pkg::STN_W-1:0]     req_station_i,
  input  wire logic [rrs_pkg::KIND_W-1:0]    req_kind_i,
  input  wire logic [rrs_pkg::STN_W-1:0]     now_station_i,
  input  wire logic                          direction_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [rrs_pkg::OUT_W-1:0]     chosen_index_o,
  output logic      [rrs_pkg::OUT_W-1:0]     removed_count_o,
  output logic      [rrs_pkg::OUT_W-1:0]     pending_count_o,
  output logic                               full_error_o
);

  import rrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  rrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .req_station_i   (req_station_i),
    .req_kind_i      (req_kind_i),
    .now_station_i   (now_station_i),
    .direction_i     (direction_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .chosen_index_o  (chosen_index_o),
    .removed_count_o (removed_count_o),
    .pending_count_o (pending_count_o),
    .full_error_o    (full_error_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/rrs_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module rrs_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/rrs_ctrl.sv =====
// Controller of the ring request scheduler: sequences insert, table scan
// and result hand-off. Depends on rrs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rrs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire rrs_pkg::sts_t sts_i,
  output rrs_pkg::cmd_t      cmd_o
);

  import rrs_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: begin
        state_d = sts_i.is_insert ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_START: begin
        cmd_o.insert    = sts_i.is_insert;
        cmd_o.scan_init = !sts_i.is_insert;
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.finish   = sts_i.scan_done;
      end
      ST_DONE: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  `RRS_ASSERT(a_accept_starts, (in_valid_i && !in_stall_o) |=> (state_q == ST_START), "accepted item did not start")
  `RRS_ASSERT(a_scan_one_cmd, !(cmd_o.scan_init && cmd_o.scan_run), "scan init and run together")

endmodule

`default_nettype wire

// ===== rtl/rrs_dp.sv =====
// Datapath of the ring request scheduler: request table RAM, scan counters,
// distance compare, compaction and the output register.
// Depends on rrs_pkg, rrs_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rrs_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [rrs_pkg::STN_W-1:0]   cfg_data_i,
  // input item
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [rrs_pkg::STN_W-1:0]   req_station_i,
  input  wire logic [rrs_pkg::KIND_W-1:0]  req_kind_i,
  input  wire logic [rrs_pkg::STN_W-1:0]   now_station_i,
  input  wire logic                        direction_i,
  // result item
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [rrs_pkg::OUT_W-1:0]   chosen_index_o,
  output logic      [rrs_pkg::OUT_W-1:0]   removed_count_o,
  output logic      [rrs_pkg::OUT_W-1:0]   pending_count_o,
  output logic                             full_error_o,
  // controller
  input  wire rrs_pkg::cmd_t               cmd_i,
  output rrs_pkg::sts_t                    sts_o
);

  import rrs_pkg::*;

  // Configuration registers
  logic [1:0]       mode_q;
  logic [STN_W-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RESET;
      total_q <= TOTAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:  mode_q  <= cfg_data_i[1:0];
        CFG_TOTAL: total_q <= cfg_data_i;
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  // Captured item
  op_e               op_q;
  logic [STN_W-1:0]  rs_q;
  logic [KIND_W-1:0] rk_q;
  logic [STN_W-1:0]  now_q;
  logic              dir_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(opcode_i);
      rs_q  <= req_station_i;
      rk_q  <= req_kind_i;
      now_q <= now_station_i;
      dir_q <= direction_i;
    end
  end

  logic is_serve;
  assign is_serve = (op_q == OP_STOP) || (op_q == OP_PASSING);

  // Scan state: issue counter, read pipeline, kept count, best pick
  logic [CNT_W-1:0]        cnt_q, issue_q, kept_q, best_q, removed_q;
  logic                    p_q;
  logic [IDX_W-1:0]        pidx_q;
  logic signed [DIST_W-1:0] gap_q;
  logic                    full_q;

  logic [ENTRY_W-1:0] rdata;
  logic [STN_W-1:0]   e_stn;
  logic [KIND_W-1:0]  e_kind;
  assign e_stn  = rdata[STN_W-1:0];
  assign e_kind = rdata[ENTRY_W-1:STN_W];

  logic issue_ok, tbl_full;
  assign issue_ok = issue_q != cnt_q;
  assign tbl_full = cnt_q == CNT_W'(TABLE_DEPTH);

  // Ring distances of the entry coming out of the RAM
  logic signed [DIST_W-1:0] s_w, n_w, t_w, d_cw, d_ccw, d_dir;
  assign s_w   = DIST_W'(e_stn);
  assign n_w   = DIST_W'(now_q);
  assign t_w   = DIST_W'(total_q);
  assign d_cw  = (s_w > n_w) ? (s_w - n_w) : (t_w - n_w + s_w);
  assign d_ccw = (s_w < n_w) ? (n_w - s_w) : (n_w + t_w - s_w);
  assign d_dir = dir_q ? d_ccw : d_cw;

  // Pick update for this entry
  logic                     take;
  logic signed [DIST_W-1:0] take_dist;
  always_comb begin
    take      = 1'b0;
    take_dist = d_cw;
    case (mode_q)
      MODE_NEAREST: begin
        if (d_cw <= d_ccw) begin
          take      = d_cw <= gap_q;
          take_dist = d_cw;
        end else begin
          take      = d_ccw < gap_q;
          take_dist = d_ccw;
        end
      end
      MODE_SWEEP: begin
        take      = d_dir < gap_q;
        take_dist = d_dir;
      end
      default: take = 1'b0;
    endcase
  end

  // Drop decision for compaction
  logic drop;
  always_comb begin
    drop = 1'b0;
    if (e_stn == now_q) begin
      if (op_q == OP_STOP) begin
        drop = 1'b1;
      end else begin
        case (mode_q)
          MODE_SWEEP:   drop = 1'b1;
          MODE_NEAREST: drop = (e_kind == KIND_TARGET) || (e_kind == KIND_W'(dir_q));
          default:      drop = 1'b0;
        endcase
      end
    end
  end

  logic proc;
  assign proc = cmd_i.scan_run && p_q;

  // Control registers of the table and the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      issue_q   <= '0;
      kept_q    <= '0;
      best_q    <= '0;
      removed_q <= '0;
      p_q       <= 1'b0;
      pidx_q    <= '0;
      gap_q     <= FAR_DIST;
      full_q    <= 1'b0;
    end else begin
      if (cmd_i.insert) begin
        full_q <= tbl_full;
        if (!tbl_full) cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.scan_init) begin
        issue_q <= '0;
        kept_q  <= '0;
        best_q  <= '0;
        gap_q   <= FAR_DIST;
        p_q     <= 1'b0;
      end
      if (cmd_i.scan_run) begin
        p_q <= issue_ok;
        if (issue_ok) begin
          issue_q <= issue_q + 1'b1;
          pidx_q  <= issue_q[IDX_W-1:0];
        end
      end
      if (proc) begin
        if (!drop) kept_q <= kept_q + 1'b1;
        if (take) begin
          gap_q  <= take_dist;
          best_q <= CNT_W'(pidx_q) + 1'b1;
        end
      end
      if (cmd_i.finish && is_serve) begin
        cnt_q     <= kept_q;
        removed_q <= cnt_q - kept_q;
      end
    end
  end

  // Table RAM: appends on insert, compaction writes during serve scans
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  always_comb begin
    if (cmd_i.insert) begin
      ram_we    = !tbl_full;
      ram_waddr = cnt_q[IDX_W-1:0];
    end else begin
      ram_we    = proc && is_serve && !drop;
      ram_waddr = kept_q[IDX_W-1:0];
    end
  end

  logic [ENTRY_W-1:0] ram_wdata;
  assign ram_wdata = cmd_i.insert ? {rk_q, rs_q} : rdata;

  rrs_ram #(
    .Width (ENTRY_W),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Result of the pick
  logic [CNT_W-1:0] pick_res;
  always_comb begin
    case (mode_q) inside
      MODE_FIFO:    pick_res = (cnt_q != '0) ? CNT_W'(1) : '0;
      MODE_NEAREST,
      MODE_SWEEP:   pick_res = best_q;
      default:      pick_res = '0;
    endcase
  end

  // Output register
  logic             out_valid_q;
  logic [OUT_W-1:0] chosen_q, rem_out_q, pend_q;
  logic             full_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      chosen_q   <= (op_q == OP_PICK) ? OUT_W'(pick_res) : '0;
      rem_out_q  <= is_serve ? OUT_W'(removed_q) : '0;
      pend_q     <= OUT_W'(cnt_q);
      full_out_q <= (op_q == OP_INSERT) && full_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_index_o  = chosen_q;
  assign removed_count_o = rem_out_q;
  assign pending_count_o = pend_q;
  assign full_error_o    = full_out_q;

  // Status to the controller
  assign sts_o.is_insert = op_q == OP_INSERT;
  assign sts_o.scan_done = !issue_ok && !p_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  `RRS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
  `RRS_ASSERT(a_compact_behind, (proc && is_serve) |-> (CNT_W'(pidx_q) >= kept_q), "compaction write ahead of read")
  `RRS_ASSERT(a_load_free, cmd_i.load_out |-> (!out_valid_q || !out_stall_i), "result overwritten while stalled")
  `RRS_ASSERT(a_issue_bound, cmd_i.scan_run |-> (issue_q <= cnt_q), "scan read beyond the entries")

endmodule

`default_nettype wire
